@@ src/nsfc_pkg.sv @@
package nsfc_pkg;

  localparam int MAX_LINE = 128;
  localparam int CNT_W = $clog2(MAX_LINE);
  localparam int MIN_LEN = 10;
  localparam int LEN_SAT = 127;
  localparam int NUM_TYPES = 6;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_N = 8'h4E;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_STAR   = 3'd2,
    ST_SHORT_SUM = 3'd3,
    ST_BAD_HEX   = 3'd4,
    ST_MISMATCH  = 3'd5
  } status_t;

  localparam logic [2:0] TALK_NONE = 3'd0;
  localparam logic [2:0] TALK_GP = 3'd1;
  localparam logic [2:0] TALK_GL = 3'd2;
  localparam logic [2:0] TALK_GA = 3'd3;
  localparam logic [2:0] TALK_BD = 3'd4;
  localparam logic [2:0] TALK_GN = 3'd5;

  localparam logic [2:0] MSG_NONE = 3'd0;

  localparam logic [23:0] TYPE_NAMES [NUM_TYPES] = '{
    24'h524D43,
    24'h474741,
    24'h475341,
    24'h475356,
    24'h565447,
    24'h474C4C
  };

  typedef struct packed {
    status_t     status;
    logic [2:0]  talker_system;
    logic [2:0]  message_type;
    logic [7:0]  computed_checksum;
    logic [7:0]  parsed_checksum;
    logic [6:0]  sentence_length;
  } result_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA + 8'd10)};
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      r = {1'b1, 4'(c - CH_LA + 8'd10)};
    end
    return r;
  endfunction

endpackage

@@ src/nmea_sentence_framer_checker_top.sv @@
// A line feed that ends a sentence is held in the input register, and its result is then
// loaded into the output register, which holds it while out_stall is high.
// Throughput: one byte per cycle; the input register stalls only when it holds a line
// feed that ends a sentence while the output register holds a result that is stalled.
// Reset: synchronous active-high rst empties both registers and clears the line state,
// so bytes are dropped until the next dollar sign.
module nmea_sentence_framer_checker_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [2:0] talker_system,
  output logic [2:0] message_type,
  output logic [7:0] computed_checksum,
  output logic [7:0] parsed_checksum,
  output logic [6:0] sentence_length
);
  import nsfc_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       emits;
  logic       out_free;
  logic       s1_adv;
  result_t    result;
  result_t    out_reg;

  nsfc_line_state u_line (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .rx_char (s1_byte),
    .emits   (emits),
    .result  (result)
  );

  assign out_free = !out_valid || !out_stall;
  assign s1_adv = s1_valid && (!emits || out_free);
  assign in_stall = s1_valid && !s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && emits) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emits) begin
      out_reg <= result;
    end
  end

  assign status = out_reg.status;
  assign talker_system = out_reg.talker_system;
  assign message_type = out_reg.message_type;
  assign computed_checksum = out_reg.computed_checksum;
  assign parsed_checksum = out_reg.parsed_checksum;
  assign sentence_length = out_reg.sentence_length;

  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && emits && out_valid && out_stall |-> in_stall)
    else $error("A result would overwrite a stalled result.");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    s1_adv && emits |=> out_valid)
    else $error("A finished sentence did not reach the output register.");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("The input stalled with an empty input register.");

endmodule

@@ src/nsfc_line_state.sv @@
module nsfc_line_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_char,
  output logic             emits,
  output nsfc_pkg::result_t result
);
  import nsfc_pkg::*;

  logic             in_sentence, in_sentence_next;
  logic [CNT_W-1:0] char_count, char_count_next;
  logic [7:0]       running_xor, running_xor_next;
  logic             star_seen, star_seen_next;
  logic [1:0]       after_star_count, after_star_count_next;
  logic [7:0]       received_sum, received_sum_next;
  logic             hex_field_ok, hex_field_ok_next;
  logic [15:0]      talker_chars, talker_chars_next;
  logic [NUM_TYPES-1:0] type_hits, type_hits_next;
  logic [15:0]      recent_chars, recent_chars_next;
  logic [4:0]       hex;
  logic [2:0]       talker;
  logic [2:0]       mtype;
  status_t          st;

  assign hex = hex_decode(rx_char);
  assign emits = in_sentence && (rx_char == CH_LF);

  always_comb begin
    in_sentence_next = in_sentence;
    char_count_next = char_count;
    running_xor_next = running_xor;
    star_seen_next = star_seen;
    after_star_count_next = after_star_count;
    received_sum_next = received_sum;
    hex_field_ok_next = hex_field_ok;
    talker_chars_next = talker_chars;
    type_hits_next = type_hits;
    recent_chars_next = recent_chars;
    if (rx_char == CH_DOLLAR) begin
      in_sentence_next = 1'b1;
      char_count_next = CNT_W'(1);
      running_xor_next = 8'd0;
      star_seen_next = 1'b0;
      after_star_count_next = 2'd0;
      received_sum_next = 8'd0;
      hex_field_ok_next = 1'b0;
      talker_chars_next = 16'd0;
      type_hits_next = '0;
      recent_chars_next = {8'd0, CH_DOLLAR};
    end else if (in_sentence && rx_char != CH_CR) begin
      if (rx_char == CH_LF) begin
        in_sentence_next = 1'b0;
      end else if (int'(char_count) >= MAX_LINE - 1) begin
        in_sentence_next = 1'b0;
      end else begin
        if (char_count == CNT_W'(1)) begin
          talker_chars_next[15:8] = rx_char;
        end
        if (char_count == CNT_W'(2)) begin
          talker_chars_next[7:0] = rx_char;
        end
        if (!star_seen) begin
          if (rx_char == CH_STAR) begin
            star_seen_next = 1'b1;
          end else begin
            running_xor_next = running_xor ^ rx_char;
          end
        end else if (after_star_count != 2'd3) begin
          case (after_star_count)
            2'd0: begin
              hex_field_ok_next = hex[4];
              received_sum_next = {hex[3:0], 4'd0};
            end
            2'd1: begin
              hex_field_ok_next = hex_field_ok && hex[4];
              received_sum_next = {received_sum[7:4], hex[3:0]};
            end
            default: begin
              if (hex[4]) begin
                hex_field_ok_next = 1'b0;
              end
            end
          endcase
          after_star_count_next = after_star_count + 2'd1;
        end
        for (int k = 0; k < NUM_TYPES; k++) begin
          if ({recent_chars, rx_char} == TYPE_NAMES[k]) begin
            type_hits_next[k] = 1'b1;
          end
        end
        recent_chars_next = {recent_chars[7:0], rx_char};
        char_count_next = char_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      char_count <= '0;
      running_xor <= 8'd0;
      star_seen <= 1'b0;
      after_star_count <= 2'd0;
      received_sum <= 8'd0;
      hex_field_ok <= 1'b0;
      talker_chars <= 16'd0;
      type_hits <= '0;
      recent_chars <= 16'd0;
    end else if (step) begin
      in_sentence <= in_sentence_next;
      char_count <= char_count_next;
      running_xor <= running_xor_next;
      star_seen <= star_seen_next;
      after_star_count <= after_star_count_next;
      received_sum <= received_sum_next;
      hex_field_ok <= hex_field_ok_next;
      talker_chars <= talker_chars_next;
      type_hits <= type_hits_next;
      recent_chars <= recent_chars_next;
    end
  end

  always_comb begin
    if (int'(char_count) <= MIN_LEN) begin
      st = ST_SHORT;
    end else if (!star_seen) begin
      st = ST_NO_STAR;
    end else if (after_star_count < 2'd2) begin
      st = ST_SHORT_SUM;
    end else if (!hex_field_ok) begin
      st = ST_BAD_HEX;
    end else if (running_xor != received_sum) begin
      st = ST_MISMATCH;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    talker = TALK_NONE;
    if (talker_chars == {CH_G, CH_P}) begin
      talker = TALK_GP;
    end else if (talker_chars == {CH_G, CH_L}) begin
      talker = TALK_GL;
    end else if (talker_chars == {CH_G, CH_A}) begin
      talker = TALK_GA;
    end else if (talker_chars == {CH_G, CH_B} || talker_chars == {CH_B, CH_D}) begin
      talker = TALK_BD;
    end else if (talker_chars == {CH_G, CH_N}) begin
      talker = TALK_GN;
    end
  end

  always_comb begin
    mtype = MSG_NONE;
    for (int k = NUM_TYPES - 1; k >= 0; k--) begin
      if (type_hits[k]) begin
        mtype = 3'(k + 1);
      end
    end
  end

  always_comb begin
    result.status = st;
    result.talker_system = (st == ST_OK) ? talker : TALK_NONE;
    result.message_type = mtype;
    result.computed_checksum = running_xor;
    result.parsed_checksum = (st == ST_OK || st == ST_MISMATCH) ? received_sum : 8'd0;
    result.sentence_length = (int'(char_count) > LEN_SAT) ? 7'(LEN_SAT) : 7'(char_count);
  end

  a_dollar_starts: assert property (@(posedge clk) disable iff (rst)
    step && rx_char == CH_DOLLAR |=> in_sentence && char_count == CNT_W'(1))
    else $error("A dollar transfer did not start a new sentence.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(char_count) <= MAX_LINE - 1)
    else $error("The character count passed the line limit.");

  a_star_before_digits: assert property (@(posedge clk) disable iff (rst)
    after_star_count != 2'd0 |-> star_seen)
    else $error("Characters were counted after an asterisk that was not seen.");

endmodule

@@ bench/nmea_sentence_framer_checker_top_test.sv @@
module nmea_sentence_framer_checker_top_test;
  import nsfc_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int RANDOM_BYTES = 540;
  localparam int QUIET_AFTER = 440;
  localparam int HANG_LIMIT = 400;

  class line_verdict_scoreboard;
    result_t expected_verdicts[$];
    int mismatches;
    bit in_line;
    int stored;
    bit [7:0] body_xor;
    bit star_found;
    bit [1:0] after_star;
    bit [7:0] sent_sum;
    bit sum_digits_ok;
    bit [7:0] talker_hi;
    bit [7:0] talker_lo;
    bit [5:0] seen_types;
    bit [7:0] char_older;
    bit [7:0] char_newer;

    static function int hex_digit(bit [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
      if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
      if (c >= CH_LA && c <= CH_LF_HEX) return int'(c) - int'(CH_LA) + 10;
      return -1;
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    function void note_rx_byte(bit [7:0] c);
      int v;
      status_t st;
      bit [2:0] talk;
      bit [2:0] kind;
      result_t verdict;
      if (c == CH_DOLLAR) begin
        in_line = 1;
        stored = 1;
        body_xor = 0;
        star_found = 0;
        after_star = 0;
        sent_sum = 0;
        sum_digits_ok = 0;
        talker_hi = 0;
        talker_lo = 0;
        seen_types = 0;
        char_older = 0;
        char_newer = CH_DOLLAR;
      end else if (in_line && c != CH_CR && c != CH_LF) begin
        if (stored >= MAX_LINE - 1) begin
          in_line = 0;
        end else begin
          if (stored == 1) talker_hi = c;
          if (stored == 2) talker_lo = c;
          if (!star_found) begin
            if (c == CH_STAR) star_found = 1;
            else body_xor ^= c;
          end else if (after_star < 3) begin
            v = hex_digit(c);
            case (after_star)
              0: begin
                sum_digits_ok = (v >= 0);
                sent_sum = (v >= 0) ? 8'(v << 4) : 8'd0;
              end
              1: begin
                sum_digits_ok = sum_digits_ok && (v >= 0);
                if (v >= 0) sent_sum[3:0] = 4'(v);
              end
              default: begin
                if (v >= 0) sum_digits_ok = 0;
              end
            endcase
            after_star++;
          end
          for (int k = 0; k < NUM_TYPES; k++) begin
            if ({char_older, char_newer, c} == TYPE_NAMES[k]) seen_types[k] = 1;
          end
          char_older = char_newer;
          char_newer = c;
          stored++;
        end
      end else if (in_line && c == CH_LF) begin
        if (stored <= MIN_LEN) st = ST_SHORT;
        else if (!star_found) st = ST_NO_STAR;
        else if (after_star < 2) st = ST_SHORT_SUM;
        else if (!sum_digits_ok) st = ST_BAD_HEX;
        else if (body_xor != sent_sum) st = ST_MISMATCH;
        else st = ST_OK;
        kind = MSG_NONE;
        for (int k = NUM_TYPES - 1; k >= 0; k--) begin
          if (seen_types[k]) kind = 3'(k + 1);
        end
        talk = TALK_NONE;
        if (st == ST_OK) begin
          case ({talker_hi, talker_lo})
            {CH_G, CH_P}: talk = TALK_GP;
            {CH_G, CH_L}: talk = TALK_GL;
            {CH_G, CH_A}: talk = TALK_GA;
            {CH_G, CH_B}, {CH_B, CH_D}: talk = TALK_BD;
            {CH_G, CH_N}: talk = TALK_GN;
            default: talk = TALK_NONE;
          endcase
        end
        verdict.status = st;
        verdict.talker_system = talk;
        verdict.message_type = kind;
        verdict.computed_checksum = body_xor;
        verdict.parsed_checksum = (st == ST_OK || st == ST_MISMATCH) ? sent_sum : 8'd0;
        verdict.sentence_length = 7'((stored > LEN_SAT) ? LEN_SAT : stored);
        expected_verdicts.push_back(verdict);
        in_line = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_verdict(logic [2:0] st, logic [2:0] talk, logic [2:0] kind,
                       logic [7:0] calc, logic [7:0] recv, logic [6:0] len);
      result_t want;
      if (expected_verdicts.size() == 0) begin
        report("result transfer with no sentence pending");
        return;
      end
      want = expected_verdicts.pop_front();
      if (st != want.status)
        report($sformatf("status got %0d expected %0d", st, want.status));
      if (talk != want.talker_system)
        report($sformatf("talker_system got %0d expected %0d", talk, want.talker_system));
      if (kind != want.message_type)
        report($sformatf("message_type got %0d expected %0d", kind, want.message_type));
      if (calc != want.computed_checksum)
        report($sformatf("computed_checksum got %h expected %h", calc,
                         want.computed_checksum));
      if (recv != want.parsed_checksum)
        report($sformatf("parsed_checksum got %h expected %h", recv,
                         want.parsed_checksum));
      if (len != want.sentence_length)
        report($sformatf("sentence_length got %0d expected %0d", len, want.sentence_length));
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_stall;
  logic [2:0] status;
  logic [2:0] talker_system;
  logic [2:0] message_type;
  logic [7:0] computed_checksum;
  logic [7:0] parsed_checksum;
  logic [6:0] sentence_length;

  line_verdict_scoreboard board = new();
  bit quiet = 0;
  int bytes_sent = 0;
  int stuck_cycles = 0;

  nmea_sentence_framer_checker_top u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .talker_system(talker_system),
    .message_type(message_type),
    .computed_checksum(computed_checksum),
    .parsed_checksum(parsed_checksum),
    .sentence_length(sentence_length)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.check_verdict(status, talker_system, message_type, computed_checksum,
                            parsed_checksum, sentence_length);
      end
      if (in_valid && !in_stall) board.note_rx_byte(rx_byte);
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= HANG_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    int left;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic bit [7:0] sum_of(byte_q_t q);
    bit [7:0] acc;
    acc = 0;
    foreach (q[i]) begin
      if (q[i] != CH_CR) acc ^= q[i];
    end
    return acc;
  endfunction

  function automatic string hex2(bit [7:0] v, bit lower);
    return lower ? $sformatf("%02x", v) : $sformatf("%02X", v);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(byte_q_t body, string tail, bit with_cr);
    send_byte(CH_DOLLAR);
    foreach (body[i]) send_byte(body[i]);
    send_text(tail);
    if (with_cr) send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  task automatic send_random_sentence();
    byte_q_t body;
    int kind;
    int n;
    int k;
    bit [7:0] s;
    bit [7:0] c;
    bit lower;
    string tail;
    string bad_set;
    bad_set = "GZgz,.*-";
    kind = $urandom_range(0, 99);
    lower = $urandom_range(0, 1);
    if (kind >= 96) begin
      repeat ($urandom_range(5, 40)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      if (kind >= 90) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 7))
        0: body = to_bytes("GP");
        1: body = to_bytes("GL");
        2: body = to_bytes("GA");
        3: body = to_bytes("GB");
        4: body = to_bytes("BD");
        5: body = to_bytes("GN");
        6: begin
          body.push_back(8'($urandom_range(65, 90)));
          body.push_back(8'($urandom_range(65, 90)));
        end
        default: begin
          body.push_back(8'($urandom_range(32, 126)));
          body.push_back(8'($urandom_range(32, 126)));
        end
      endcase
      k = $urandom_range(0, 7);
      for (int i = 2; i >= 0; i--) begin
        if (k < NUM_TYPES) body.push_back(TYPE_NAMES[k][i*8 +: 8]);
        else body.push_back(8'($urandom_range(65, 90)));
      end
      n = (kind >= 86 && kind < 90) ? $urandom_range(112, 124) : $urandom_range(0, 30);
      while (body.size() < n + 5) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: body.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
          10, 11, 12: body.push_back(",");
          13: body.push_back(".");
          14, 15, 16, 17: body.push_back(8'($urandom_range(65, 90)));
          18: body.push_back(8'($urandom_range(97, 122)));
          default: begin
            k = $urandom_range(0, NUM_TYPES - 1);
            for (int i = 2; i >= 0; i--) body.push_back(TYPE_NAMES[k][i*8 +: 8]);
          end
        endcase
      end
      if (kind >= 80 && kind < 86) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 3))
            0: c = 8'h00;
            1: c = CH_CR;
            2: c = 8'($urandom_range(128, 255));
            default: c = 8'($urandom_range(0, 255));
          endcase
          body.insert($urandom_range(0, body.size()), c);
        end
      end
      s = sum_of(body);
      if (kind < 55 || kind >= 80) begin
        tail = {"*", hex2(s, lower)};
      end else if (kind < 63) begin
        tail = {"*", hex2(s ^ 8'($urandom_range(1, 255)), lower)};
      end else if (kind < 67) begin
        tail = "";
      end else if (kind < 71) begin
        tail = $urandom_range(0, 1) ? "*" : $sformatf("*%1X", $urandom_range(0, 15));
      end else if (kind < 76) begin
        c = bad_set[$urandom_range(0, 7)];
        if ($urandom_range(0, 1)) tail = $sformatf("*%c%1x", c, $urandom_range(0, 15));
        else tail = $sformatf("*%1X%c", $urandom_range(0, 15), c);
      end else begin
        if ($urandom_range(0, 1)) c = 8'(CH_ZERO + $urandom_range(0, 9));
        else c = bad_set[$urandom_range(0, 7)];
        tail = $sformatf("*%s%cM,1", hex2(s, lower), c);
      end
      send_line(body, tail, $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    byte_q_t b;
    int random_start;
    int lines;
    rst <= 1'b1;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_text("a,");
    send_byte(CH_LF);
    send_byte(CH_DOLLAR);
    send_byte(CH_LF);
    send_text("$GPGGA,12");
    send_byte(CH_LF);
    send_text("$GPGGA,123");
    send_byte(CH_LF);
    b = to_bytes("GPRMC,081836,A,3751.65,S");
    send_line(b, {"*", hex2(sum_of(b), 0)}, 1);
    b = to_bytes("GLGGA,1,2,3,4");
    send_line(b, {"*", hex2(sum_of(b), 1)}, 0);
    b = to_bytes("GAGSA,A,3,04");
    send_line(b, {"*", hex2(sum_of(b) ^ 8'h5A, 0)}, 1);
    b = to_bytes("GBGSV,2,1,08");
    send_line(b, "", 1);
    b = to_bytes("BDVTG,054.7,T");
    send_line(b, "*4", 1);
    send_line(b, "*", 1);
    b = to_bytes("GNGLL,4916.45,N");
    send_line(b, "*G1", 1);
    send_line(b, "*1g", 1);
    send_line(b, {"*", hex2(sum_of(b), 0), "7"}, 1);
    send_line(b, {"*", hex2(sum_of(b), 1), "*9Q"}, 1);
    b = to_bytes("GNGLL,VTG,GSV,GSA,GGA");
    send_line(b, {"*", hex2(sum_of(b), 0)}, 1);
    b = to_bytes("XXRMX,12,34,56");
    send_line(b, {"*", hex2(sum_of(b), 0)}, 1);
    b = to_bytes("GPRMC,GPRMC,");
    send_line(b, {"*", hex2(sum_of(b), 0)}, 1);
    b = to_bytes("GPRMC,1");
    send_line(b, "*FF", 1);
    send_text("$GPRMC,1,2");
    b = to_bytes("GNRMC,5,6");
    send_line(b, {"*", hex2(sum_of(b), 0)}, 1);
    b = to_bytes("GPVTG,1");
    b.push_back(8'h00);
    b.push_back(CH_CR);
    b.push_back(8'hFF);
    b.push_back(",");
    b.push_back("2");
    send_line(b, {"*", hex2(sum_of(b), 1)}, 1);
    b = to_bytes("GPGGA");
    while (b.size() < 123) b.push_back(8'(CH_ZERO + b.size() % 10));
    send_line(b, {"*", hex2(sum_of(b), 0)}, 1);
    b.push_back(",");
    send_line(b, {"*", hex2(sum_of(b), 0)}, 1);
    send_text("12");
    send_byte(CH_LF);
    wait_drained();

    random_start = bytes_sent;
    lines = 0;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      if (bytes_sent - random_start > QUIET_AFTER) quiet = 1;
      send_random_sentence();
      lines++;
      if (lines % 16 == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
